// ----- design/csls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csls_pkg: shared types and constants of the source line splicer
// Character codes and the per-result tag that travels from the step logic
// to the result queue.
// ----------------------------------------------------------------------------
package csls_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BSL = 8'h5C;

  // character and end flag of one result
  typedef struct packed {
    logic [7:0] chr;
    logic       is_end;
  } res_tag_t;

  // what one step produces besides the counts
  typedef struct packed {
    logic     has_r0;
    logic     has_r1;
    res_tag_t r0;
    res_tag_t r1;
  } step_res_t;

  // splicer flags kept between bytes
  typedef struct packed {
    logic after_cr;
    logic held_bsl;
    logic last_nl;
  } flags_t;

endpackage

// ----- design/csls_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csls_step: one input beat of the splicer
// Works out up to two results, their line and column, and the next flags
// and counts from the current state and one byte or end marker.
// ----------------------------------------------------------------------------
module csls_step #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic [7:0]             data_byte,
  input  logic                   end_of_input,
  input  csls_pkg::flags_t       flags,
  input  logic [LINE_BITS-1:0]   line_cnt,
  input  logic [COLUMN_BITS-1:0] col_cnt,
  output csls_pkg::step_res_t    res,
  output logic [LINE_BITS-1:0]   r0_line,
  output logic [COLUMN_BITS-1:0] r0_col,
  output logic [LINE_BITS-1:0]   r1_line,
  output logic [COLUMN_BITS-1:0] r1_col,
  output csls_pkg::flags_t       flags_nxt,
  output logic [LINE_BITS-1:0]   line_nxt,
  output logic [COLUMN_BITS-1:0] col_nxt
);

  localparam logic [LINE_BITS-1:0]   LineMax = '1;
  localparam logic [COLUMN_BITS-1:0] ColMax  = '1;
  localparam logic [LINE_BITS-1:0]   LineOne = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] ColOne  = COLUMN_BITS'(1);

  logic [7:0]             canon;
  logic [7:0]             cnt_chr;
  logic [LINE_BITS-1:0]   line_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic                   drop_lf;

  // CR turns into LF; the end marker counts as an added LF
  assign canon   = (data_byte == csls_pkg::CH_CR) ? csls_pkg::CH_LF : data_byte;
  assign cnt_chr = end_of_input ? csls_pkg::CH_LF : canon;
  assign drop_lf = flags.after_cr && (data_byte == csls_pkg::CH_LF);

  // saturating position update for the one character counted this beat
  always_comb begin
    if (cnt_chr == csls_pkg::CH_LF) begin
      line_inc = (line_cnt != LineMax) ? line_cnt + LineOne : line_cnt;
      col_inc  = ColOne;
    end else begin
      line_inc = line_cnt;
      col_inc  = (col_cnt != ColMax) ? col_cnt + ColOne : col_cnt;
    end
  end

  always_comb begin
    res       = '0;
    r0_line   = line_inc;
    r0_col    = col_inc;
    r1_line   = line_inc;
    r1_col    = col_inc;
    flags_nxt = flags;
    line_nxt  = line_cnt;
    col_nxt   = col_cnt;
    if (end_of_input) begin
      // end: splice a held backslash or add a missing LF, then restart
      flags_nxt = '0;
      line_nxt  = LineOne;
      col_nxt   = ColOne;
      if (flags.held_bsl) begin
        res.has_r0    = 1'b1;
        res.r0.is_end = 1'b1;
      end else if (!flags.last_nl) begin
        res.has_r0    = 1'b1;
        res.r0.chr    = csls_pkg::CH_LF;
        res.has_r1    = 1'b1;
        res.r1.is_end = 1'b1;
      end else begin
        res.has_r0    = 1'b1;
        res.r0.is_end = 1'b1;
        r0_line       = line_cnt;
        r0_col        = col_cnt;
      end
    end else if (drop_lf) begin
      // LF of a CR LF pair leaves no trace
      flags_nxt.after_cr = 1'b0;
    end else begin
      flags_nxt.after_cr = (data_byte == csls_pkg::CH_CR);
      flags_nxt.last_nl  = (canon == csls_pkg::CH_LF);
      line_nxt           = line_inc;
      col_nxt            = col_inc;
      if (flags.held_bsl) begin
        flags_nxt.held_bsl = 1'b0;
        if (canon != csls_pkg::CH_LF) begin
          // held backslash goes out first, with the counts it left
          res.has_r0 = 1'b1;
          res.r0.chr = csls_pkg::CH_BSL;
          r0_line    = line_cnt;
          r0_col     = col_cnt;
          if (canon == csls_pkg::CH_BSL) begin
            flags_nxt.held_bsl = 1'b1;
          end else begin
            res.has_r1 = 1'b1;
            res.r1.chr = canon;
          end
        end
      end else if (canon == csls_pkg::CH_BSL) begin
        flags_nxt.held_bsl = 1'b1;
      end else begin
        res.has_r0 = 1'b1;
        res.r0.chr = canon;
      end
    end
  end

endmodule

// ----- design/c_source_line_splicer.sv -----
`timescale 1ns / 1ps
// path: a beat waits in the input register, and its results enter the result queue and leave from its head
// throughput: one byte per cycle while no byte gives two results and out_stall is low;
//   a byte that gives two results must pass both through the single result port
// the three-entry result queue sets the pace: a beat is processed when two slots are free
// reset: synchronous, active low; clears the queue and sets line and column to one
// ----------------------------------------------------------------------------
// c_source_line_splicer: line splicing and newline canonicalization
// Input register, one step of splice logic, and a small result queue whose
// head drives the output ports.
// ----------------------------------------------------------------------------
module c_source_line_splicer #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_input,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_char_out,
  output logic                   out_is_end,
  output logic [LINE_BITS-1:0]   out_line_no,
  output logic [COLUMN_BITS-1:0] out_column_no,
  output logic                   out_last_of_run
);

  localparam int QDepth = 3;

  typedef struct packed {
    csls_pkg::res_tag_t     tag;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } qent_t;

  // input register
  logic                   ivld_r, ivld_nxt;
  logic [7:0]             ibyte_r;
  logic                   iend_r;
  // splicer state
  csls_pkg::flags_t       flags_r, flags_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  // result queue, head at slot zero
  qent_t                  q_r   [QDepth];
  qent_t                  q_nxt [QDepth];
  logic [1:0]             qcnt_r, qcnt_nxt;

  csls_pkg::step_res_t    sres;
  logic [LINE_BITS-1:0]   r0_line, r1_line;
  logic [COLUMN_BITS-1:0] r0_col, r1_col;
  csls_pkg::flags_t       sflags;
  logic [LINE_BITS-1:0]   sline;
  logic [COLUMN_BITS-1:0] scol;
  logic                   proc, in_acc, pop;
  logic [1:0]             base;
  qent_t                  e0, e1;

  csls_step #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_step (
    .data_byte   (ibyte_r),
    .end_of_input(iend_r),
    .flags       (flags_r),
    .line_cnt    (line_r),
    .col_cnt     (col_r),
    .res         (sres),
    .r0_line     (r0_line),
    .r0_col      (r0_col),
    .r1_line     (r1_line),
    .r1_col      (r1_col),
    .flags_nxt   (sflags),
    .line_nxt    (sline),
    .col_nxt     (scol)
  );

  // handshake: process when the queue has room for two results
  assign proc      = ivld_r && (qcnt_r <= 2'd1);
  assign in_stall  = ivld_r && !proc;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (qcnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign ivld_nxt  = in_acc || (ivld_r && !proc);

  // entries built from this step
  assign e0 = '{tag: sres.r0, line: r0_line, col: r0_col, last: !sres.has_r1};
  assign e1 = '{tag: sres.r1, line: r1_line, col: r1_col, last: 1'b1};
  assign base = qcnt_r - {1'b0, pop};

  // queue shift on pop, then append new results
  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && (i < QDepth - 1)) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (proc && sres.has_r0 && (2'(i) == base)) begin
        q_nxt[i] = e0;
      end
      if (proc && sres.has_r1 && (2'(i) == base + 2'd1)) begin
        q_nxt[i] = e1;
      end
    end
    qcnt_nxt = base;
    if (proc) begin
      qcnt_nxt = base + {1'b0, sres.has_r0} + {1'b0, sres.has_r1};
    end
  end

  // splicer state advances when a beat is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r  <= 1'b0;
      qcnt_r  <= 2'd0;
      flags_r <= '0;
      line_r  <= LINE_BITS'(1);
      col_r   <= COLUMN_BITS'(1);
    end else begin
      ivld_r <= ivld_nxt;
      qcnt_r <= qcnt_nxt;
      if (proc) begin
        flags_r <= sflags;
        line_r  <= sline;
        col_r   <= scol;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ibyte_r <= in_data_byte;
      iend_r  <= in_end_of_input;
    end
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // head of the queue drives the result beat
  assign out_char_out    = q_r[0].tag.chr;
  assign out_is_end      = q_r[0].tag.is_end;
  assign out_line_no     = q_r[0].line;
  assign out_column_no   = q_r[0].col;
  assign out_last_of_run = q_r[0].last;

endmodule

// ----- design/csls_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csls_checker: port level checks of the source line splicer
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module csls_checker #(
  parameter int LINE_BITS   = 24,
  parameter int COLUMN_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [7:0]             out_char_out,
  input logic                   out_is_end,
  input logic [LINE_BITS-1:0]   out_line_no,
  input logic [COLUMN_BITS-1:0] out_column_no,
  input logic                   out_last_of_run
);

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out)
      && $stable(out_is_end) && $stable(out_line_no) && $stable(out_column_no))
    else $error("stalled result beat changed");

  // end beat closes its run and carries no character
  a_end_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_last_of_run && (out_char_out == 8'h00))
    else $error("malformed end beat");

  // a CR never leaves the block
  a_no_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_out != csls_pkg::CH_CR))
    else $error("CR in result stream");

  // an LF result starts a new line at column one
  a_lf_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_end && (out_char_out == csls_pkg::CH_LF)
      |-> (out_column_no == COLUMN_BITS'(1)))
    else $error("LF result not at column one");

endmodule

bind c_source_line_splicer csls_checker #(
  .LINE_BITS  (LINE_BITS),
  .COLUMN_BITS(COLUMN_BITS)
) u_csls_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char_out   (out_char_out),
  .out_is_end     (out_is_end),
  .out_line_no    (out_line_no),
  .out_column_no  (out_column_no),
  .out_last_of_run(out_last_of_run)
);
